// ===== hw/rtl/pidc_pkg.sv =====
// Package for the PID controller step unit: configuration register
// indexes, command codes, field widths, the configuration struct and the
// symmetric clamp. No dependencies.
package pidc_pkg;

  // Field widths
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned SAMP_W  = 16;
  localparam int unsigned ERR_W   = 17;
  localparam int unsigned DIFF_W  = 18;
  localparam int unsigned ACC_W   = 32;
  localparam int unsigned LIM_W   = 31;
  localparam int unsigned ELIM_W  = 17;
  localparam int unsigned SUM_W   = 34;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned CDATA_W = 31;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [CIDX_W-1:0] REG_DERIV_GAIN = 3'd2;
  localparam logic [CIDX_W-1:0] REG_ERR_CLAMP  = 3'd3;
  localparam logic [CIDX_W-1:0] REG_INTEG_CLAMP = 3'd4;
  localparam logic [CIDX_W-1:0] REG_OUT_CLAMP  = 3'd5;
  localparam logic [CIDX_W-1:0] REG_SEP_THRESH = 3'd6;
  localparam logic [CIDX_W-1:0] REG_MODE_BITS  = 3'd7;

  // Command codes
  localparam logic CMD_RUN   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // Bit positions within mode_bits
  localparam int unsigned MODE_ERR_CLAMP = 0;
  localparam int unsigned MODE_SEPARATE  = 1;

  // Reset values of the limits
  localparam logic [ELIM_W-1:0] ELIM_RESET = 17'h10000;
  localparam logic [LIM_W-1:0]  LIM_RESET  = 31'h7FFF_FFFF;

  // Configuration registers as seen by the datapath
  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integ_gain;
    logic [GAIN_W-1:0] deriv_gain;
    logic [ELIM_W-1:0] error_clamp;
    logic [LIM_W-1:0]  integ_clamp;
    logic [LIM_W-1:0]  out_clamp;
    logic [ELIM_W-1:0] sep_thresh;
    logic [MODE_W-1:0] mode_bits;
  } pidc_cfg_t;

  // Clamp x to the range -lim .. lim. A limit of zero forces zero.
  function automatic logic signed [SUM_W-1:0] clamp_sym(
    input logic signed [SUM_W-1:0] x,
    input logic [LIM_W-1:0] lim
  );
    logic signed [SUM_W-1:0] l;
    logic signed [SUM_W-1:0] r;
    l = $signed({3'b000, lim});
    r = x;
    if (r >= l) r = l;
    if (r <= -l) r = -l;
    return r;
  endfunction

endpackage

// ===== hw/rtl/pidc_datapath.sv =====
// Combinational arithmetic of one PID run step: error, derivative,
// clamping, integral update and output sum. Depends on pidc_pkg.
module pidc_datapath (
  input  pidc_pkg::pidc_cfg_t       cfg_i,
  input  logic [15:0]               setpoint_i,
  input  logic [15:0]               measured_i,
  input  logic [16:0]               prev_err_i,
  input  logic [31:0]               integ_acc_i,
  output logic [16:0]               err_o,
  output logic [31:0]               integ_acc_o,
  output logic [31:0]               drive_o
);
  import pidc_pkg::*;

  logic signed [ERR_W-1:0]  err_raw;
  logic signed [ERR_W-1:0]  err_c;
  logic signed [SUM_W-1:0]  err_clamped_wide;
  logic [ERR_W-1:0]         err_mag;
  logic signed [DIFF_W-1:0] diff;
  logic signed [32:0]       prod_p;
  logic signed [32:0]       prod_i;
  logic signed [33:0]       prod_d;
  logic signed [24:0]       term_p;
  logic signed [24:0]       term_i;
  logic signed [25:0]       term_d;
  logic                     integrate;
  logic signed [SUM_W-1:0]  acc_sum;
  logic signed [SUM_W-1:0]  acc_clamped;
  logic signed [SUM_W-1:0]  drive_sum;
  logic signed [SUM_W-1:0]  drive_clamped;

  // Raw error and derivative, both before error clamping
  assign err_raw = $signed({setpoint_i[15], setpoint_i}) - $signed({measured_i[15], measured_i});
  assign diff    = $signed({err_raw[ERR_W-1], err_raw}) - $signed({prev_err_i[16], prev_err_i});

  // Optional symmetric error clamp; the result never grows in magnitude
  assign err_clamped_wide = clamp_sym($signed({{(SUM_W-ERR_W){err_raw[ERR_W-1]}}, err_raw}),
                                      {{(LIM_W-ELIM_W){1'b0}}, cfg_i.error_clamp});
  assign err_c = cfg_i.mode_bits[MODE_ERR_CLAMP] ? err_clamped_wide[ERR_W-1:0] : err_raw;

  // Integral separation test on the clamped error
  assign err_mag   = err_c[ERR_W-1] ? ERR_W'(-err_c) : ERR_W'(err_c);
  assign integrate = !cfg_i.mode_bits[MODE_SEPARATE] || (err_mag <= cfg_i.sep_thresh);

  // Gain products; dropping the low eight bits is a floor division by 256
  assign prod_p = $signed({{17{cfg_i.prop_gain[15]}}, cfg_i.prop_gain})
                * $signed({{16{err_c[ERR_W-1]}}, err_c});
  assign prod_i = $signed({{17{cfg_i.integ_gain[15]}}, cfg_i.integ_gain})
                * $signed({{16{err_c[ERR_W-1]}}, err_c});
  assign prod_d = $signed({{18{cfg_i.deriv_gain[15]}}, cfg_i.deriv_gain})
                * $signed({{16{diff[DIFF_W-1]}}, diff});
  assign term_p = prod_p[32:8];
  assign term_i = prod_i[32:8];
  assign term_d = prod_d[33:8];

  // Integral update, clamped on every run step
  always_comb begin
    acc_sum = $signed({{2{integ_acc_i[31]}}, integ_acc_i});
    if (integrate) begin
      acc_sum = acc_sum + $signed({{9{term_i[24]}}, term_i});
    end
  end
  assign acc_clamped = clamp_sym(acc_sum, cfg_i.integ_clamp);

  // Output sum and clamp
  assign drive_sum = $signed({{9{term_p[24]}}, term_p})
                   + $signed({{2{acc_clamped[31]}}, acc_clamped[31:0]})
                   + $signed({{8{term_d[25]}}, term_d});
  assign drive_clamped = clamp_sym(drive_sum, cfg_i.out_clamp);

  assign err_o       = err_c;
  assign integ_acc_o = acc_clamped[31:0];
  assign drive_o     = drive_clamped[31:0];

endmodule

// ===== hw/rtl/pid_controller_step_unit.sv =====
// Top level of the PID controller step unit: configuration registers,
// input and result registers, controller state. Depends on pidc_pkg and
// pidc_datapath.
//
// Usage:
//   The input channel (in_valid_i / in_stall_o) carries one beat per control
//   item: cmd_i, setpoint_i and measured_i. The result channel
//   (out_valid_o / out_stall_i) returns exactly one beat per item in drive_o.
//   A run command performs one PID step; a clear command zeroes the
//   integral and returns the last drive.
//   From input beat to result beat, the item first sits in the input
//   register, then the whole step is computed in one pass and lands in
//   the result register together with the state update.
//   Throughput is one item per cycle while out_stall_i is low; feedback
//   through the integral and error history closes in one combinational pass.
//   When the receiver stalls, the result register holds its beat, the input
//   register fills and then in_stall_o rises; nothing is dropped.
//   Reset clears both valid flags, the integral, the last drive and the
//   error history, and loads the configuration reset values.
//   Configuration registers are written via cfg_we_i/cfg_idx_i/cfg_wdata_i; the
//   user must write them only while no item is in flight; the block does not enforce it.
module pid_controller_step_unit #(
  parameter int unsigned DERIV_GAP = 1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [30:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [15:0] setpoint_i,
  input  logic [15:0] measured_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] drive_o
);
  import pidc_pkg::*;

  pidc_cfg_t        cfg_q;

  logic             in_valid_q;
  logic             in_cmd_q;
  logic [15:0]      in_setpoint_q;
  logic [15:0]      in_measured_q;

  logic             out_valid_q;
  logic [31:0]      drive_q;

  logic [31:0]      integ_acc_q;
  logic [31:0]      last_drive_q;
  logic [ERR_W-1:0] err_line_q [DERIV_GAP];

  logic             res_ready;
  logic             in_ready;
  logic             step_fire;
  logic [ERR_W-1:0] err_new;
  logic [31:0]      integ_acc_new;
  logic [31:0]      drive_new;

  // Handshake: the result register frees when its beat is taken
  assign res_ready  = !out_valid_q || !out_stall_i;
  assign in_ready   = !in_valid_q || res_ready;
  assign step_fire  = in_valid_q && res_ready;
  assign in_stall_o = !in_ready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain   <= '0;
      cfg_q.integ_gain  <= '0;
      cfg_q.deriv_gain  <= '0;
      cfg_q.error_clamp <= ELIM_RESET;
      cfg_q.integ_clamp <= LIM_RESET;
      cfg_q.out_clamp   <= LIM_RESET;
      cfg_q.sep_thresh  <= ELIM_RESET;
      cfg_q.mode_bits   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PROP_GAIN:   cfg_q.prop_gain   <= cfg_wdata_i[GAIN_W-1:0];
        REG_INTEG_GAIN:  cfg_q.integ_gain  <= cfg_wdata_i[GAIN_W-1:0];
        REG_DERIV_GAIN:  cfg_q.deriv_gain  <= cfg_wdata_i[GAIN_W-1:0];
        REG_ERR_CLAMP:   cfg_q.error_clamp <= cfg_wdata_i[ELIM_W-1:0];
        REG_INTEG_CLAMP: cfg_q.integ_clamp <= cfg_wdata_i[LIM_W-1:0];
        REG_OUT_CLAMP:   cfg_q.out_clamp   <= cfg_wdata_i[LIM_W-1:0];
        REG_SEP_THRESH:  cfg_q.sep_thresh  <= cfg_wdata_i[ELIM_W-1:0];
        REG_MODE_BITS:   cfg_q.mode_bits   <= cfg_wdata_i[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      in_cmd_q      <= cmd_i;
      in_setpoint_q <= setpoint_i;
      in_measured_q <= measured_i;
    end
  end

  // One-pass step arithmetic
  pidc_datapath u_datapath (
    .cfg_i       (cfg_q),
    .setpoint_i  (in_setpoint_q),
    .measured_i  (in_measured_q),
    .prev_err_i  (err_line_q[DERIV_GAP-1]),
    .integ_acc_i (integ_acc_q),
    .err_o       (err_new),
    .integ_acc_o (integ_acc_new),
    .drive_o     (drive_new)
  );

  // Controller state, updated as an item moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_acc_q  <= '0;
      last_drive_q <= '0;
      for (int i = 0; i < DERIV_GAP; i++) begin
        err_line_q[i] <= '0;
      end
    end else if (step_fire) begin
      if (in_cmd_q == CMD_CLEAR) begin
        integ_acc_q <= '0;
      end else begin
        integ_acc_q   <= integ_acc_new;
        last_drive_q  <= drive_new;
        err_line_q[0] <= err_new;
        for (int i = 1; i < DERIV_GAP; i++) begin
          err_line_q[i] <= err_line_q[i-1];
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      drive_q <= (in_cmd_q == CMD_CLEAR) ? last_drive_q : drive_new;
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;

  // A clear beat leaves the integral at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_fire && (in_cmd_q == CMD_CLEAR) |=> integ_acc_q == '0)
    else $error("integral not cleared by clear beat");

  // A run beat delivers the same value it records as the last drive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_fire && (in_cmd_q == CMD_RUN) |=> out_valid_q && (drive_q == last_drive_q))
    else $error("result beat and last drive disagree");

  // An item held in the input register while the result side is blocked keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !res_ready |=> in_valid_q && $stable(in_setpoint_q)
                                 && $stable(in_measured_q) && $stable(in_cmd_q))
    else $error("input register lost a stalled beat");

  // The state only moves when an item passes into the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_fire |=> $stable(integ_acc_q) && $stable(last_drive_q))
    else $error("controller state changed without a beat");

endmodule
